// File: rtl/core/lcfg_pkg.sv
// ----------------------------------------------------------------------------
// Candle flicker generator package
// Shared constants, register codes and beat/entry types.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfg_pkg;

   localparam int LED_COUNT_DEF   = 4;
   localparam int CURVE_STEPS_DEF = 128;

   localparam int LED_SEL_W  = 2;
   localparam int CURVE_W    = 7;
   localparam int LEVEL_W    = 8;
   localparam int FCOUNT_W   = 5;
   localparam int FDEPTH_W   = 4;
   localparam int GLOW_W     = 7;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int GLOW_MIN_LEN = 30;

   typedef enum logic [2:0] {
      REG_BASE_LEVEL     = 3'd0,
      REG_GLOW_SPAN      = 3'd1,
      REG_FLICKER_CHANCE = 3'd2,
      REG_GLOW_CHANCE    = 3'd3,
      REG_RAMP_STEP      = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [LED_SEL_W-1:0] led_sel;
      logic                 tick_end;
      logic [7:0]           rnd_flicker_test;
      logic [2:0]           rnd_flicker_depth;
      logic [7:0]           rnd_glow_test;
      logic [4:0]           rnd_glow_length;
      logic                 rnd_glow_up;
   } req_beat_type;

   typedef struct packed {
      logic [LED_SEL_W-1:0] led_out;
      logic [CURVE_W-1:0]   curve_index;
   } rsp_beat_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]         level;
      logic [FCOUNT_W-1:0]        flick_count;
      logic [FDEPTH_W-1:0]        flick_depth;
      logic signed [GLOW_W-1:0]   glow_count;
   } led_entry_type;

endpackage

`default_nettype wire

// File: rtl/core/led_candle_flicker_generator.sv
// ----------------------------------------------------------------------------
// Candle flicker generator
// Per-LED candle brightness model: startup ramp, flicker and glow.
//
// Each req beat is one LED update within a tick and carries the LED index,
// the end-of-tick mark and the random fields. Each beat returns exactly one
// rsp beat with the LED index and the saturated curve index, in order.
// Per-LED state lives in a small RAM with registered read; a
// write-to-read bypass covers back-to-back updates of the same LED.
// An accepted req beat is registered in the update stage and then in the rsp
// register; one beat is taken every cycle while rsp is not stalled.
// A stalled rsp holds its beat; one more beat waits in the update stage,
// after which req_stall rises.
// Synchronous reset clears all LED state to zero (entry valid bits, no
// clearing pass), clears the startup flag and loads register defaults:
// base 75, glow span 25, flicker chance 8, glow chance 16, ramp step 1.
// Registers sit on the csr port at byte addresses 4*i; the user must write
// them only while the block is idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module led_candle_flicker_generator #(
   parameter int LED_COUNT   = lcfg_pkg::LED_COUNT_DEF,
   parameter int CURVE_STEPS = lcfg_pkg::CURVE_STEPS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire lcfg_pkg::req_beat_type              req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output lcfg_pkg::rsp_beat_type                   rsp_data,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [lcfg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [lcfg_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [lcfg_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

   localparam int IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int SelW = (IdxW > lcfg_pkg::LED_SEL_W) ? IdxW : lcfg_pkg::LED_SEL_W;
   localparam int EntW = $bits(lcfg_pkg::led_entry_type);
   localparam logic [9:0] CurveLim = 10'(CURVE_STEPS);
   localparam logic [8:0] CurveMax = 9'(CURVE_STEPS - 1);

   // configuration
   logic [6:0] base_level_ff;
   logic [5:0] glow_span_ff;
   logic [7:0] flick_chance_ff;
   logic [7:0] glow_chance_ff;
   logic [3:0] ramp_step_ff;
   logic       csr_write;
   lcfg_pkg::csr_reg_type csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = lcfg_pkg::csr_reg_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_level_ff   <= 7'd75;
         glow_span_ff    <= 6'd25;
         flick_chance_ff <= 8'd8;
         glow_chance_ff  <= 8'd16;
         ramp_step_ff    <= 4'd1;
      end else if (csr_write) begin
         case (csr_reg)
            lcfg_pkg::REG_BASE_LEVEL:     base_level_ff   <= csr_pwdata[6:0];
            lcfg_pkg::REG_GLOW_SPAN:      glow_span_ff    <= csr_pwdata[5:0];
            lcfg_pkg::REG_FLICKER_CHANCE: flick_chance_ff <= csr_pwdata[7:0];
            lcfg_pkg::REG_GLOW_CHANCE:    glow_chance_ff  <= csr_pwdata[7:0];
            lcfg_pkg::REG_RAMP_STEP:      ramp_step_ff    <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         lcfg_pkg::REG_BASE_LEVEL:     csr_prdata = 32'(base_level_ff);
         lcfg_pkg::REG_GLOW_SPAN:      csr_prdata = 32'(glow_span_ff);
         lcfg_pkg::REG_FLICKER_CHANCE: csr_prdata = 32'(flick_chance_ff);
         lcfg_pkg::REG_GLOW_CHANCE:    csr_prdata = 32'(glow_chance_ff);
         lcfg_pkg::REG_RAMP_STEP:      csr_prdata = 32'(ramp_step_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic                   s1_valid_ff;
   lcfg_pkg::req_beat_type s1_beat_ff;
   logic                   rsp_valid_ff;
   lcfg_pkg::rsp_beat_type rsp_beat_ff;
   logic                   req_accept;
   logic                   s1_fire;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_beat_ff;

   // state memory and bypass
   logic [SelW-1:0]         req_sel_ext;
   logic [IdxW-1:0]         rd_addr;
   logic [SelW-1:0]         s1_sel_ext;
   logic [IdxW-1:0]         s1_addr;
   logic                    s1_in_range;
   logic                    wr_en;
   logic [EntW-1:0]         ram_rd;
   lcfg_pkg::led_entry_type wr_entry;
   lcfg_pkg::led_entry_type cur_entry;
   logic                    byp_valid_ff;
   lcfg_pkg::led_entry_type byp_entry_ff;
   logic                    entry_valid_ff [LED_COUNT];
   logic [7:0]              shadow_level_ff [LED_COUNT];
   logic                    ramp_done_ff;
   logic                    ramp_done_in;

   assign req_sel_ext = SelW'(req_data.led_sel);
   assign rd_addr     = req_sel_ext[IdxW-1:0];
   assign s1_sel_ext  = SelW'(s1_beat_ff.led_sel);
   assign s1_addr     = s1_sel_ext[IdxW-1:0];
   assign s1_in_range = (int'(s1_sel_ext) < LED_COUNT);
   assign wr_en       = s1_fire && s1_in_range;

   lcfg_ram #(
      .WIDTH(EntW),
      .DEPTH(LED_COUNT)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(s1_addr),
      .wr_data(wr_entry),
      .rd_en  (req_accept),
      .rd_addr(rd_addr),
      .rd_data(ram_rd)
   );

   always_comb begin
      if (byp_valid_ff) begin
         cur_entry = byp_entry_ff;
      end else if (s1_in_range && entry_valid_ff[s1_addr]) begin
         cur_entry = lcfg_pkg::led_entry_type'(ram_rd);
      end else begin
         cur_entry = '0;
      end
   end

   // per-LED update
   logic [7:0]        lvl;
   logic [7:0]        new_lvl;
   logic [4:0]        offset;
   logic [8:0]        ramp_sum;
   logic [8:0]        glow_top;
   logic signed [9:0] glow_low;
   logic signed [9:0] lvl_s;
   logic [4:0]        fc_dec;
   logic [4:0]        fd_twice;
   logic [3:0]        fd_new;
   logic [6:0]        glow_len;
   logic signed [6:0] g_step;
   logic [8:0]        idx_sum;
   logic [8:0]        idx_sat;

   assign lvl      = cur_entry.level;
   assign ramp_sum = 9'(lvl) + 9'(ramp_step_ff);
   assign glow_top = 9'(base_level_ff) + 9'(glow_span_ff);
   assign glow_low = $signed(10'(base_level_ff)) - $signed(10'(glow_span_ff));
   assign lvl_s    = $signed(10'(lvl));
   assign fc_dec   = cur_entry.flick_count - 5'd1;
   assign fd_twice = {cur_entry.flick_depth, 1'b0};
   assign fd_new   = 4'(s1_beat_ff.rnd_flicker_depth) + 4'd1;
   assign glow_len = 7'(lcfg_pkg::GLOW_MIN_LEN) + 7'(s1_beat_ff.rnd_glow_length);

   always_comb begin
      wr_entry = cur_entry;
      new_lvl  = lvl;
      offset   = '0;
      g_step   = '0;
      if (!ramp_done_ff) begin
         if (lvl < 8'(base_level_ff)) begin
            new_lvl = (ramp_sum > 9'(base_level_ff)) ? 8'(base_level_ff) : ramp_sum[7:0];
         end
      end else if (cur_entry.flick_count != '0) begin
         wr_entry.flick_count = fc_dec;
         if (fc_dec < 5'(cur_entry.flick_depth)) begin
            offset = fc_dec;
         end else if (fd_twice >= fc_dec) begin
            offset = fd_twice - fc_dec;
         end
      end else if (s1_beat_ff.rnd_flicker_test < flick_chance_ff) begin
         wr_entry.flick_depth = fd_new;
         wr_entry.flick_count = {fd_new, 1'b0};
      end else if (cur_entry.glow_count != '0) begin
         if (cur_entry.glow_count > 7'sd0) begin
            g_step = cur_entry.glow_count - 7'sd1;
            if (9'(lvl) < glow_top) begin
               new_lvl = lvl + 8'd1;
            end else begin
               g_step = 7'sd0 - g_step;
            end
         end else begin
            g_step = cur_entry.glow_count + 7'sd1;
            if ((lvl_s > glow_low) && (lvl != 8'd0)) begin
               new_lvl = lvl - 8'd1;
            end else begin
               g_step = 7'sd0 - g_step;
            end
         end
         wr_entry.glow_count = g_step;
      end else if (s1_beat_ff.rnd_glow_test < glow_chance_ff) begin
         wr_entry.glow_count = s1_beat_ff.rnd_glow_up ? $signed(glow_len)
                                                      : 7'sd0 - $signed(glow_len);
      end
      wr_entry.level = new_lvl;
   end

   assign idx_sum = 9'(new_lvl) + 9'(offset);
   assign idx_sat = ({1'b0, idx_sum} >= CurveLim) ? CurveMax : idx_sum;

   // startup flag over levels after this update
   logic any_below;

   always_comb begin
      any_below = 1'b0;
      for (int i = 0; i < LED_COUNT; i++) begin
         if (s1_in_range && (int'(s1_addr) == i)) begin
            if (new_lvl < 8'(base_level_ff)) any_below = 1'b1;
         end else begin
            if (shadow_level_ff[i] < 8'(base_level_ff)) any_below = 1'b1;
         end
      end
      ramp_done_in = ramp_done_ff;
      if (s1_fire && s1_beat_ff.tick_end && !ramp_done_ff) begin
         ramp_done_in = !any_below;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
         ramp_done_ff <= 1'b0;
         for (int i = 0; i < LED_COUNT; i++) begin
            entry_valid_ff[i]  <= 1'b0;
            shadow_level_ff[i] <= '0;
         end
      end else begin
         ramp_done_ff <= ramp_done_in;
         if (req_accept) begin
            s1_valid_ff  <= 1'b1;
            byp_valid_ff <= wr_en && (s1_addr == rd_addr);
         end else if (s1_fire) begin
            s1_valid_ff  <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            entry_valid_ff[s1_addr]  <= 1'b1;
            shadow_level_ff[s1_addr] <= new_lvl;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_beat_ff   <= req_data;
         byp_entry_ff <= wr_entry;
      end
      if (s1_fire) begin
         rsp_beat_ff.led_out     <= s1_beat_ff.led_sel;
         rsp_beat_ff.curve_index <= s1_in_range ? idx_sat[6:0] : '0;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/lcfg_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfg_ram #(
   parameter int WIDTH = $bits(lcfg_pkg::led_entry_type),
   parameter int DEPTH = lcfg_pkg::LED_COUNT_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/lcfg_checker.sv
// ----------------------------------------------------------------------------
// Candle flicker generator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfg_checker #(
   parameter int LED_COUNT = lcfg_pkg::LED_COUNT_DEF
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire lcfg_pkg::rsp_beat_type rsp_data
);

   // hold a stalled rsp beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed under stall");

   // stall req only when rsp is blocked
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled while rsp free");

   // deliver an accepted beat after the update stage when rsp drains
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("rsp beat late");

   // drop out-of-range LED updates to index zero
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (int'(rsp_data.led_out) >= LED_COUNT) |-> rsp_data.curve_index == '0)
      else $error("out-of-range LED gave non-zero index");

   // no rsp right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind led_candle_flicker_generator lcfg_checker #(
   .LED_COUNT(LED_COUNT)
) u_lcfg_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

`default_nettype wire

// File: dv/lcfg_curve_checker.sv
// ----------------------------------------------------------------------------
// Candle flicker curve checker
// Follows register writes, predicts the curve index of every accepted req
// beat from its own copy of the per-LED state, and compares each accepted
// rsp beat with the oldest prediction. Counts mismatches for the top level.
// ----------------------------------------------------------------------------
module lcfg_curve_checker
   import lcfg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_beat_type          req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_beat_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatches,
   output int                    outstanding
);

   logic [6:0]    base_level;
   logic [5:0]    glow_span;
   logic [7:0]    flicker_chance;
   logic [7:0]    glow_chance;
   logic [3:0]    ramp_step;
   led_entry_type leds [LED_COUNT_DEF];
   logic          ramp_done;
   rsp_beat_type  curve_q [$];

   function automatic rsp_beat_type advance_led(input req_beat_type beat);
      int           n;
      int           lvl;
      int           offset;
      int           cnt;
      int           dep;
      int           g;
      int           low;
      int           base;
      int           span;
      int           idx;
      bit           lit;
      rsp_beat_type res;
      n      = int'(beat.led_sel);
      lvl    = int'(leds[n].level);
      base   = int'(base_level);
      span   = int'(glow_span);
      offset = 0;
      if (!ramp_done) begin
         if (lvl < base) begin
            lvl = lvl + int'(ramp_step);
            if (lvl > base) lvl = base;
         end
      end else if (leds[n].flick_count != '0) begin
         cnt = int'(leds[n].flick_count) - 1;
         dep = int'(leds[n].flick_depth);
         leds[n].flick_count = FCOUNT_W'(cnt);
         if (cnt < dep) offset = cnt;
         else if (2 * dep >= cnt) offset = 2 * dep - cnt;
      end else if (int'(beat.rnd_flicker_test) < int'(flicker_chance)) begin
         dep = int'(beat.rnd_flicker_depth) + 1;
         leds[n].flick_depth = FDEPTH_W'(dep);
         leds[n].flick_count = FCOUNT_W'(2 * dep);
      end else if (leds[n].glow_count != '0) begin
         g = int'(leds[n].glow_count);
         if (g > 0) begin
            g = g - 1;
            if (lvl < base + span) lvl = lvl + 1;
            else g = -g;
         end else begin
            low = base - span;
            g   = g + 1;
            if (lvl > low && lvl > 0) lvl = lvl - 1;
            else g = -g;
         end
         leds[n].glow_count = GLOW_W'(g);
      end else if (int'(beat.rnd_glow_test) < int'(glow_chance)) begin
         g = GLOW_MIN_LEN + int'(beat.rnd_glow_length);
         leds[n].glow_count = beat.rnd_glow_up ? GLOW_W'(g) : GLOW_W'(-g);
      end
      leds[n].level = LEVEL_W'(lvl);
      idx = int'(leds[n].level) + offset;
      if (idx > CURVE_STEPS_DEF - 1) idx = CURVE_STEPS_DEF - 1;
      if (beat.tick_end && !ramp_done) begin
         lit = 1'b1;
         foreach (leds[i]) if (int'(leds[i].level) < base) lit = 1'b0;
         ramp_done = lit;
      end
      res.led_out     = beat.led_sel;
      res.curve_index = CURVE_W'(idx);
      return res;
   endfunction

   always @(posedge clock) begin
      int           errs;
      rsp_beat_type want;
      errs = 0;
      if (reset) begin
         base_level     = 7'd75;
         glow_span      = 6'd25;
         flicker_chance = 8'd8;
         glow_chance    = 8'd16;
         ramp_step      = 4'd1;
         foreach (leds[i]) leds[i] = '0;
         ramp_done = 1'b0;
         curve_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_BASE_LEVEL:     base_level     = csr_pwdata[6:0];
               REG_GLOW_SPAN:      glow_span      = csr_pwdata[5:0];
               REG_FLICKER_CHANCE: flicker_chance = csr_pwdata[7:0];
               REG_GLOW_CHANCE:    glow_chance    = csr_pwdata[7:0];
               REG_RAMP_STEP:      ramp_step      = csr_pwdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) curve_q.push_back(advance_led(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (curve_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got led %0d index %0d",
                        $time, rsp_data.led_out, rsp_data.curve_index);
               errs = errs + 1;
            end else begin
               want = curve_q.pop_front();
               if (rsp_data.led_out != want.led_out) begin
                  $display("%0t: led_out expected %0d, got %0d",
                           $time, want.led_out, rsp_data.led_out);
                  errs = errs + 1;
               end
               if (rsp_data.curve_index != want.curve_index) begin
                  $display("%0t: led %0d curve_index expected %0d, got %0d",
                           $time, want.led_out, want.curve_index, rsp_data.curve_index);
                  errs = errs + 1;
               end
            end
         end
      end
      mismatches  <= mismatches + errs;
      outstanding <= curve_q.size();
   end

endmodule

// File: dv/led_candle_flicker_generator_tb.sv
// ----------------------------------------------------------------------------
// Candle flicker generator testbench
// Drives LED update beats in tick order with random content, a little noise
// and varied register settings, with random gaps on both channels. The
// checker beside the block predicts and compares; this level gives the verdict.
// ----------------------------------------------------------------------------
module led_candle_flicker_generator_tb;
   import lcfg_pkg::*;

   localparam int         SETTING_COUNT     = 7;
   localparam int         BEATS_PER_SETTING = 158;
   localparam int         RANDOM_BEATS      = SETTING_COUNT * BEATS_PER_SETTING;
   localparam logic [2:0] REG_SPARE_LO      = 3'd5;
   localparam logic [2:0] REG_SPARE_HI      = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid;
   logic                  req_stall;
   req_beat_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_beat_type          rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatches;
   int                    outstanding;
   int                    gap_pct;
   int                    stall_pct = 0;

   led_candle_flicker_generator DUT (.*);

   lcfg_curve_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   function automatic req_beat_type random_beat(input logic [1:0] led, input logic tick);
      req_beat_type b;
      b.led_sel           = led;
      b.tick_end          = tick;
      b.rnd_flicker_test  = 8'($urandom_range(255));
      b.rnd_flicker_depth = 3'($urandom_range(7));
      b.rnd_glow_test     = 8'($urandom_range(255));
      b.rnd_glow_length   = 5'($urandom_range(31));
      b.rnd_glow_up       = 1'($urandom_range(1));
      return b;
   endfunction

   function automatic req_beat_type corner_beat(input logic [1:0] led, input logic tick,
                                                input logic hi);
      req_beat_type b;
      b          = hi ? '1 : '0;
      b.led_sel  = led;
      b.tick_end = tick;
      return b;
   endfunction

   task automatic set_idling(input int n);
      case (n * 3 / RANDOM_BEATS)
         0: begin
            gap_pct   = 23;
            stall_pct <= 62;
         end
         1: begin
            gap_pct   = 62;
            stall_pct <= 23;
         end
         default: begin
            gap_pct   = 0;
            stall_pct <= 0;
         end
      endcase
   endtask

   task automatic send_beat(input req_beat_type beat);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= (32'($urandom) << 8) | 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic program_regs(input int base, input int span, input int fch, input int gch,
                               input int step, input logic [2:0] spare);
      write_reg(REG_BASE_LEVEL, base);
      write_reg(REG_GLOW_SPAN, span);
      write_reg(REG_FLICKER_CHANCE, fch);
      write_reg(REG_GLOW_CHANCE, gch);
      write_reg(REG_RAMP_STEP, step);
      write_reg(spare, int'($urandom_range(255)));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int sent;
      int led_pos;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      set_idling(0);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hold the level at zero: startup must not finish
      program_regs(127, 25, 8, 16, 0, REG_SPARE_LO);
      for (int i = 0; i < 8; i++) send_beat(corner_beat(2'(i), i % 4 == 3, i >= 4));
      settle();
      program_regs(127, 25, 8, 16, 15, REG_SPARE_HI);
      for (int i = 0; i < 8; i++) send_beat(corner_beat(2'(i), i % 4 == 3, i[0]));
      // same LED back to back, tick end out of place
      for (int i = 0; i < 4; i++) send_beat(corner_beat(2'd2, i == 1, i[1]));
      send_beat(corner_beat(2'd1, 1'b0, 1'b1));
      send_beat(corner_beat(2'd3, 1'b1, 1'b0));

      sent    = 0;
      led_pos = 0;
      for (int s = 0; s < SETTING_COUNT; s++) begin
         settle();
         case (s)
            0: program_regs(75, 25, 8, 16, 4, REG_SPARE_LO);
            1: program_regs(127, 63, 255, 255, 15, REG_SPARE_HI);
            2: program_regs(0, 0, 0, 255, 1, REG_SPARE_LO);
            3: program_regs(10, 63, 40, 255, 0, REG_SPARE_HI);
            4: program_regs(100, 27, 20, 200, 7, REG_SPARE_LO);
            5: program_regs($urandom_range(127), $urandom_range(63), $urandom_range(255),
                            $urandom_range(255), $urandom_range(15), REG_SPARE_HI);
            default: program_regs(60, 5, 30, 0, 1, REG_SPARE_LO);
         endcase
         for (int k = 0; k < BEATS_PER_SETTING; k++) begin
            set_idling(sent);
            if (k == BEATS_PER_SETTING / 2) settle();
            if ($urandom_range(99) < 85) begin
               send_beat(random_beat(2'(led_pos), led_pos == 3));
               led_pos = (led_pos + 1) % 4;
            end else begin
               send_beat(random_beat(2'($urandom_range(3)), 1'($urandom_range(1))));
            end
            sent++;
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/lcfg_pkg.sv
rtl/core/lcfg_ram.sv
rtl/core/led_candle_flicker_generator.sv
rtl/core/lcfg_checker.sv
dv/lcfg_curve_checker.sv
dv/led_candle_flicker_generator_tb.sv
